/* sv/top_n_score_table_core_assert.svh */
// ----------------------------------------------------------------------------
// top_n_score_table_core_assert.svh
// Assertion macros used by the score table core.
// ----------------------------------------------------------------------------
`ifndef TOP_N_SCORE_TABLE_CORE_ASSERT_SVH
`define TOP_N_SCORE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TNST_AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TNST_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tnst_pkg.sv */
// ----------------------------------------------------------------------------
// tnst_pkg
// Widths, entry type and sequencer states of the top-N score table.
// ----------------------------------------------------------------------------
`default_nettype none

package tnst_pkg;

  localparam int DEPTH   = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int OWNER_W = 32;
  localparam int ITEM_W  = 16;
  localparam int SCORE_W = 32;
  localparam int RANK_W  = 5;
  localparam int COUNT_W = 6;

  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [ITEM_W-1:0]  item;
    logic [SCORE_W-1:0] score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_RDATA  = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_DECIDE = 7'b0001000,
    ST_SHIFT  = 7'b0010000,
    ST_WRITE  = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

/* sv/tnst_in_if.sv */
// ----------------------------------------------------------------------------
// tnst_in_if
// Request channel of the score table: offers and rank reads.
// ----------------------------------------------------------------------------
`default_nettype none

interface tnst_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [tnst_pkg::OWNER_W-1:0] owner_id;
  logic [tnst_pkg::ITEM_W-1:0]  item_code;
  logic [tnst_pkg::SCORE_W-1:0] score;
  logic                         privileged;
  logic                         qualifies;
  logic [tnst_pkg::RANK_W-1:0]  rank_index;

  modport source (
    output valid, action, owner_id, item_code, score, privileged, qualifies, rank_index,
    input  ready
  );

  modport sink (
    input  valid, action, owner_id, item_code, score, privileged, qualifies, rank_index,
    output ready
  );
endinterface

`default_nettype wire

/* sv/tnst_out_if.sv */
// ----------------------------------------------------------------------------
// tnst_out_if
// Result channel of the score table: one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tnst_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic                         entry_valid;
  logic [tnst_pkg::OWNER_W-1:0] entry_owner;
  logic [tnst_pkg::ITEM_W-1:0]  entry_item;
  logic [tnst_pkg::SCORE_W-1:0] entry_score;
  logic [tnst_pkg::COUNT_W-1:0] entry_count;
  logic [tnst_pkg::OWNER_W-1:0] top_owner;

  modport source (
    output valid, accepted, entry_valid, entry_owner, entry_item, entry_score,
           entry_count, top_owner,
    input  ready
  );

  modport sink (
    input  valid, accepted, entry_valid, entry_owner, entry_item, entry_score,
           entry_count, top_owner,
    output ready
  );
endinterface

`default_nettype wire

/* sv/tnst_ram.sv */
// ----------------------------------------------------------------------------
// tnst_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tnst_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/top_n_score_table_core.sv */
// ----------------------------------------------------------------------------
// top_n_score_table_core
// Leaderboard of up to DEPTH (owner, item, score) entries in descending
// score order, held in one RAM and maintained by a small sequencer.
//
// in_req carries one request: an offer (action 0) or a read of a rank
// (action 1). out_rsp returns exactly one result per request, in order.
// A read passes through ST_RDATA and ST_RESP to the result register; a read
// past the count or a privileged or non-qualifying offer goes straight to
// ST_RESP. Any other offer scans the table through the RAM read port, one
// entry per cycle, then moves the entries between the old and new place one
// per cycle and, if it is taken, writes the offer. The RAM read port and the
// single score/owner comparator set that pace.
// in_req.ready is high only while the sequencer is idle, which it is again
// once each result is loaded. The result register lets a new request
// start while the last result still waits; a finished request holds in a wait
// state while out_rsp stalls. Synchronous reset empties the table at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "top_n_score_table_core_assert.svh"

module top_n_score_table_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tnst_in_if.sink     in_req,
  tnst_out_if.source  out_rsp
);

  tnst_pkg::state_t state_r, state_nxt;
  tnst_pkg::cnt_t   cnt_r, cnt_nxt;

  // offer under work and its scan results
  tnst_pkg::entry_t new_r, new_nxt;
  logic             found_r, found_nxt;
  tnst_pkg::addr_t  rem_r, rem_nxt;
  tnst_pkg::cnt_t   pos_r, pos_nxt;
  logic             append_r, append_nxt;

  // read issue sequencer, shared by scan and shift
  logic             iss_on_r, iss_on_nxt;
  logic             iss_down_r, iss_down_nxt;
  tnst_pkg::addr_t  iss_idx_r, iss_idx_nxt;
  tnst_pkg::addr_t  iss_last_r, iss_last_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  tnst_pkg::addr_t  rd_idx_r, rd_idx_nxt;

  logic [tnst_pkg::OWNER_W-1:0] top_owner_r, top_owner_nxt;

  // pending result
  logic             res_acc_r, res_acc_nxt;
  logic             res_vld_r, res_vld_nxt;
  tnst_pkg::entry_t res_entry_r, res_entry_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_acc_r, out_acc_nxt;
  logic                         out_vld_r, out_vld_nxt;
  tnst_pkg::entry_t             out_entry_r, out_entry_nxt;
  logic [tnst_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [tnst_pkg::OWNER_W-1:0] out_top_r, out_top_nxt;

  // RAM ports
  logic             ram_we;
  tnst_pkg::addr_t  ram_waddr;
  tnst_pkg::entry_t ram_wdata;
  tnst_pkg::addr_t  ram_raddr;
  tnst_pkg::entry_t ram_rdata;

  // compare unit
  logic owner_eq, score_ge, score_gt;

  logic [tnst_pkg::CNT_W+tnst_pkg::RANK_W-1:0] rank_wide, cnt_rank_wide;
  logic                                         rank_ok;
  logic [tnst_pkg::CNT_W+tnst_pkg::COUNT_W-1:0] cnt_out_wide;
  tnst_pkg::cnt_t                               cnt_m1;

  tnst_ram #(
    .WIDTH (tnst_pkg::ENTRY_W),
    .DEPTH (tnst_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign owner_eq = (ram_rdata.owner == new_r.owner);
  assign score_ge = (ram_rdata.score >= new_r.score);
  assign score_gt = score_ge && (ram_rdata.score != new_r.score);

  assign rank_wide     = {{tnst_pkg::CNT_W{1'b0}}, in_req.rank_index};
  assign cnt_rank_wide = {{tnst_pkg::RANK_W{1'b0}}, cnt_r};
  assign rank_ok       = (rank_wide < cnt_rank_wide);
  assign cnt_out_wide  = {{tnst_pkg::COUNT_W{1'b0}}, cnt_r};
  assign cnt_m1        = cnt_r - tnst_pkg::cnt_t'(1);

  assign in_req.ready        = (state_r == tnst_pkg::ST_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.accepted    = out_acc_r;
  assign out_rsp.entry_valid = out_vld_r;
  assign out_rsp.entry_owner = out_entry_r.owner;
  assign out_rsp.entry_item  = out_entry_r.item;
  assign out_rsp.entry_score = out_entry_r.score;
  assign out_rsp.entry_count = out_count_r;
  assign out_rsp.top_owner   = out_top_r;

  always_comb begin
    tnst_pkg::addr_t rem_sel;
    tnst_pkg::addr_t pos_a;
    logic            take;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    new_nxt       = new_r;
    found_nxt     = found_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    append_nxt    = append_r;
    iss_on_nxt    = iss_on_r;
    iss_down_nxt  = iss_down_r;
    iss_idx_nxt   = iss_idx_r;
    iss_last_nxt  = iss_last_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    res_acc_nxt   = res_acc_r;
    res_vld_nxt   = res_vld_r;
    res_entry_nxt = res_entry_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_acc_nxt   = out_acc_r;
    out_vld_nxt   = out_vld_r;
    out_entry_nxt = out_entry_r;
    out_count_nxt = out_count_r;
    out_top_nxt   = out_top_r;
    ram_we        = 1'b0;
    ram_waddr     = rem_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = iss_idx_r;
    rem_sel       = rem_r;
    pos_a         = pos_r[tnst_pkg::ADDR_W-1:0];
    take          = 1'b1;

    // issue one RAM read per cycle while the sequencer runs
    if (iss_on_r) begin
      rd_vld_nxt = 1'b1;
      rd_idx_nxt = iss_idx_r;
      if (iss_idx_r == iss_last_r) begin
        iss_on_nxt = 1'b0;
      end else if (iss_down_r) begin
        iss_idx_nxt = iss_idx_r - tnst_pkg::addr_t'(1);
      end else begin
        iss_idx_nxt = iss_idx_r + tnst_pkg::addr_t'(1);
      end
    end

    unique case (state_r)
      tnst_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          res_acc_nxt   = 1'b0;
          res_vld_nxt   = 1'b0;
          res_entry_nxt = '0;
          if (in_req.action == tnst_pkg::ACT_READ) begin
            if (rank_ok) begin
              ram_raddr = rank_wide[tnst_pkg::ADDR_W-1:0];
              state_nxt = tnst_pkg::ST_RDATA;
            end else begin
              state_nxt = tnst_pkg::ST_RESP;
            end
          end else if (in_req.privileged || !in_req.qualifies) begin
            state_nxt = tnst_pkg::ST_RESP;
          end else begin
            new_nxt.owner = in_req.owner_id;
            new_nxt.item  = in_req.item_code;
            new_nxt.score = in_req.score;
            found_nxt     = 1'b0;
            pos_nxt       = '0;
            iss_on_nxt    = (cnt_r != '0);
            iss_down_nxt  = 1'b0;
            iss_idx_nxt   = '0;
            iss_last_nxt  = cnt_m1[tnst_pkg::ADDR_W-1:0];
            state_nxt     = tnst_pkg::ST_SCAN;
          end
        end
      end

      tnst_pkg::ST_RDATA: begin
        res_vld_nxt   = 1'b1;
        res_entry_nxt = ram_rdata;
        state_nxt     = tnst_pkg::ST_RESP;
      end

      tnst_pkg::ST_SCAN: begin
        // count entries that stay ahead: ties ahead of the owner's old slot
        // stay ahead, ties behind it stay behind
        if (rd_vld_r) begin
          if (!found_r && owner_eq) begin
            found_nxt = 1'b1;
            rem_nxt   = rd_idx_r;
          end else if (found_r ? score_gt : score_ge) begin
            pos_nxt = pos_r + tnst_pkg::cnt_t'(1);
          end
        end
        if (!iss_on_r && !rd_vld_r) begin
          state_nxt = tnst_pkg::ST_DECIDE;
        end
      end

      tnst_pkg::ST_DECIDE: begin
        if (found_r) begin
          append_nxt = 1'b0;
          rem_sel    = rem_r;
        end else if (cnt_r < tnst_pkg::cnt_t'(tnst_pkg::DEPTH)) begin
          append_nxt = 1'b1;
          rem_sel    = cnt_r[tnst_pkg::ADDR_W-1:0];
        end else if (pos_r < tnst_pkg::cnt_t'(tnst_pkg::DEPTH)) begin
          // full: evict the last entry
          append_nxt = 1'b0;
          rem_sel    = tnst_pkg::addr_t'(tnst_pkg::DEPTH - 1);
        end else begin
          take = 1'b0;
        end
        rem_nxt = rem_sel;
        if (!take) begin
          state_nxt = tnst_pkg::ST_RESP;
        end else if (pos_a < rem_sel) begin
          iss_on_nxt   = 1'b1;
          iss_down_nxt = 1'b1;
          iss_idx_nxt  = rem_sel - tnst_pkg::addr_t'(1);
          iss_last_nxt = pos_a;
          state_nxt    = tnst_pkg::ST_SHIFT;
        end else if (pos_a > rem_sel) begin
          iss_on_nxt   = 1'b1;
          iss_down_nxt = 1'b0;
          iss_idx_nxt  = rem_sel + tnst_pkg::addr_t'(1);
          iss_last_nxt = pos_a;
          state_nxt    = tnst_pkg::ST_SHIFT;
        end else begin
          state_nxt = tnst_pkg::ST_WRITE;
        end
      end

      tnst_pkg::ST_SHIFT: begin
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = iss_down_r ? rd_idx_r + tnst_pkg::addr_t'(1)
                                 : rd_idx_r - tnst_pkg::addr_t'(1);
          ram_wdata = ram_rdata;
        end
        if (!iss_on_r && !rd_vld_r) begin
          state_nxt = tnst_pkg::ST_WRITE;
        end
      end

      tnst_pkg::ST_WRITE: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_a;
        ram_wdata   = new_r;
        res_acc_nxt = 1'b1;
        if (append_r) begin
          cnt_nxt = cnt_r + tnst_pkg::cnt_t'(1);
        end
        state_nxt = tnst_pkg::ST_RESP;
      end

      tnst_pkg::ST_RESP: begin
        // hold until the result register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_vld_nxt   = res_vld_r;
          out_entry_nxt = res_entry_r;
          out_count_nxt = cnt_out_wide[tnst_pkg::COUNT_W-1:0];
          out_top_nxt   = (cnt_r != '0) ? top_owner_r : '0;
          state_nxt     = tnst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tnst_pkg::ST_IDLE;
      end
    endcase

    top_owner_nxt = top_owner_r;
    if (ram_we && (ram_waddr == '0)) begin
      top_owner_nxt = ram_wdata.owner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tnst_pkg::ST_IDLE;
      cnt_r       <= '0;
      iss_on_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_on_r    <= iss_on_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r       <= new_nxt;
    found_r     <= found_nxt;
    rem_r       <= rem_nxt;
    pos_r       <= pos_nxt;
    append_r    <= append_nxt;
    iss_down_r  <= iss_down_nxt;
    iss_idx_r   <= iss_idx_nxt;
    iss_last_r  <= iss_last_nxt;
    rd_idx_r    <= rd_idx_nxt;
    top_owner_r <= top_owner_nxt;
    res_acc_r   <= res_acc_nxt;
    res_vld_r   <= res_vld_nxt;
    res_entry_r <= res_entry_nxt;
    out_acc_r   <= out_acc_nxt;
    out_vld_r   <= out_vld_nxt;
    out_entry_r <= out_entry_nxt;
    out_count_r <= out_count_nxt;
    out_top_r   <= out_top_nxt;
  end

  `TNST_AST_IMPL(a_cnt_bound, 1'b1, cnt_r <= tnst_pkg::cnt_t'(tnst_pkg::DEPTH),
                 "count beyond depth")
  `TNST_AST_NEXT(a_cnt_write_only, state_r != tnst_pkg::ST_WRITE, $stable(cnt_r),
                 "count moved outside write")
  `TNST_AST_IMPL(a_we_state, ram_we,
                 (state_r == tnst_pkg::ST_SHIFT) || (state_r == tnst_pkg::ST_WRITE),
                 "RAM write outside shift or write")
  `TNST_AST_IMPL(a_rd_state, rd_vld_r,
                 (state_r == tnst_pkg::ST_SCAN) || (state_r == tnst_pkg::ST_SHIFT),
                 "read data pending outside scan or shift")

endmodule

`default_nettype wire

/* tb/top_n_score_table_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_n_score_table_core_tb
// Self-checking bench for the top-N score table. A scoreboard class keeps its
// own sorted copy of the table, predicts one result per accepted request and
// checks every result in order. Directed requests cover ties, replacement,
// drops and reads past the count. Random offers from a small owner pool then
// fill the table and drive evictions. Both channels idle at random.
// ----------------------------------------------------------------------------

module top_n_score_table_core_tb;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_ITEMS   = 300;
  localparam int POOL_SIZE    = 48;
  localparam int DRAIN_CYCLES = 2 * tnst_pkg::DEPTH + 20;

  typedef logic [tnst_pkg::OWNER_W-1:0] owner_t;
  typedef logic [tnst_pkg::ITEM_W-1:0]  item_t;
  typedef logic [tnst_pkg::SCORE_W-1:0] score_t;
  typedef logic [tnst_pkg::RANK_W-1:0]  rank_t;
  typedef logic [tnst_pkg::COUNT_W-1:0] count_t;

  typedef struct packed {
    logic   action;
    owner_t owner;
    item_t  item;
    score_t score;
    logic   privileged;
    logic   qualifies;
    rank_t  rank;
  } request_t;

  typedef struct packed {
    logic   accepted;
    logic   entry_valid;
    owner_t entry_owner;
    item_t  entry_item;
    score_t entry_score;
    count_t entry_count;
    owner_t top_owner;
  } reply_t;

  // Sorted table copy plus the queue of replies still owed by the block.
  class leaderboard_checker;
    tnst_pkg::entry_t rows[tnst_pkg::DEPTH];
    int unsigned      fill;
    reply_t           owed_replies[$];
    int               mismatches;
    int               offers_taken;
    int               offers_dropped;
    int               reads_hit;
    int               reads_miss;

    function new();
      fill = 0;
      mismatches = 0;
      offers_taken = 0;
      offers_dropped = 0;
      reads_hit = 0;
      reads_miss = 0;
      foreach (rows[i]) rows[i] = '0;
    endfunction

    // Stable insertion sort, highest score first.
    function void resort();
      tnst_pkg::entry_t cur;
      int               j;
      for (int i = 1; i < fill; i++) begin
        cur = rows[i];
        j = i;
        while (j > 0 && rows[j-1].score < cur.score) begin
          rows[j] = rows[j-1];
          j--;
        end
        rows[j] = cur;
      end
    endfunction

    function bit place_offer(tnst_pkg::entry_t e);
      for (int i = 0; i < fill; i++) begin
        if (rows[i].owner == e.owner) begin
          rows[i].item  = e.item;
          rows[i].score = e.score;
          resort();
          return 1'b1;
        end
      end
      if (fill < tnst_pkg::DEPTH) begin
        rows[fill] = e;
        fill++;
        resort();
        return 1'b1;
      end
      // Full: go ahead of the first strictly lower score, evict the last.
      for (int i = 0; i < fill; i++) begin
        if (e.score > rows[i].score) begin
          for (int k = int'(fill) - 1; k > i; k--) rows[k] = rows[k-1];
          rows[i] = e;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(request_t r);
      reply_t           want;
      tnst_pkg::entry_t e;
      bit               took;
      want = '0;
      took = 1'b0;
      if (r.action == tnst_pkg::ACT_OFFER) begin
        e.owner = r.owner;
        e.item  = r.item;
        e.score = r.score;
        if (!r.privileged && r.qualifies) took = place_offer(e);
        want.accepted = took;
        if (took) offers_taken++;
        else offers_dropped++;
      end else if (r.rank < fill) begin
        want.entry_valid = 1'b1;
        want.entry_owner = rows[r.rank].owner;
        want.entry_item  = rows[r.rank].item;
        want.entry_score = rows[r.rank].score;
        reads_hit++;
      end else begin
        reads_miss++;
      end
      want.entry_count = count_t'(fill);
      want.top_owner   = (fill > 0) ? rows[0].owner : '0;
      owed_replies = {owed_replies, want};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (owed_replies.size() == 0) begin
        $error("result arrived with no request pending");
        mismatches++;
        return;
      end
      want = owed_replies.pop_front();
      compare_field("accepted",    32'(want.accepted),    32'(got.accepted));
      compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
      compare_field("entry_owner", 32'(want.entry_owner), 32'(got.entry_owner));
      compare_field("entry_item",  32'(want.entry_item),  32'(got.entry_item));
      compare_field("entry_score", 32'(want.entry_score), 32'(got.entry_score));
      compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      compare_field("top_owner",   32'(want.top_owner),   32'(got.top_owner));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;

  tnst_in_if  req_if();
  tnst_out_if rsp_if();

  leaderboard_checker board;

  top_n_score_table_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Note requests before checking results within the same edge.
  always @(posedge clk) begin
    request_t seen_req;
    reply_t   seen_rsp;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        seen_req.action     = req_if.action;
        seen_req.owner      = req_if.owner_id;
        seen_req.item       = req_if.item_code;
        seen_req.score      = req_if.score;
        seen_req.privileged = req_if.privileged;
        seen_req.qualifies  = req_if.qualifies;
        seen_req.rank       = req_if.rank_index;
        board.note_request(seen_req);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        seen_rsp.accepted    = rsp_if.accepted;
        seen_rsp.entry_valid = rsp_if.entry_valid;
        seen_rsp.entry_owner = rsp_if.entry_owner;
        seen_rsp.entry_item  = rsp_if.entry_item;
        seen_rsp.entry_score = rsp_if.entry_score;
        seen_rsp.entry_count = rsp_if.entry_count;
        seen_rsp.top_owner   = rsp_if.top_owner;
        board.check_reply(seen_rsp);
      end
    end
  end

  // Result side: accept, with random stall bursts until the calm tail.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Leaves valid high on return so back-to-back requests keep it asserted.
  task automatic send_request(request_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= r.action;
    req_if.owner_id   <= r.owner;
    req_if.item_code  <= r.item;
    req_if.score      <= r.score;
    req_if.privileged <= r.privileged;
    req_if.qualifies  <= r.qualifies;
    req_if.rank_index <= r.rank;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic post_offer(owner_t owner, item_t item, score_t score,
                            logic privileged = 1'b0, logic qualifies = 1'b1);
    request_t r;
    r = '0;
    r.action     = tnst_pkg::ACT_OFFER;
    r.owner      = owner;
    r.item       = item;
    r.score      = score;
    r.privileged = privileged;
    r.qualifies  = qualifies;
    send_request(r);
  endtask

  task automatic post_read(rank_t rank);
    request_t r;
    r = '0;
    r.action = tnst_pkg::ACT_READ;
    r.rank   = rank;
    send_request(r);
  endtask

  initial begin
    owner_t   owner_pool[POOL_SIZE];
    request_t r;
    int       pick;

    board = new();
    calm  = 1'b0;
    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.action     <= tnst_pkg::ACT_OFFER;
    req_if.owner_id   <= '0;
    req_if.item_code  <= '0;
    req_if.score      <= '0;
    req_if.privileged <= 1'b0;
    req_if.qualifies  <= 1'b0;
    req_if.rank_index <= '0;

    foreach (owner_pool[i]) owner_pool[i] = $urandom();
    owner_pool[0] = '0;
    owner_pool[1] = '1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, drops, extremes, ties, replacement, past the count.
    post_read(rank_t'(0));
    post_read(rank_t'(31));
    post_offer(32'h0000_0011, 16'h1234, 32'd50, 1'b1, 1'b1);
    post_offer(32'h0000_0012, 16'h1234, 32'd50, 1'b0, 1'b0);
    post_offer(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    post_offer(32'h0000_0000, 16'h0000, 32'h0000_0000);
    post_offer(32'h0000_0005, 16'h0001, 32'd100);
    post_offer(32'h0000_0006, 16'h0002, 32'd100);
    post_offer(32'h0000_0007, 16'h0003, 32'd100);
    post_offer(32'h0000_0005, 16'h0001, 32'd100);
    post_offer(32'h0000_0007, 16'h0004, 32'd200);
    post_offer(32'h0000_0005, 16'h0005, 32'd100);
    post_offer(32'hFFFF_FFFF, 16'hAAAA, 32'd0);
    post_offer(32'h0000_0006, 16'h5555, 32'hFFFF_FFFF, 1'b1, 1'b0);
    for (int i = 0; i < 7; i++) post_read(rank_t'(i));
    post_read(rank_t'(31));

    // Random: mostly pooled owners so the table fills, ties and evictions recur.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      r.action     = ($urandom_range(0, 99) < 35) ? tnst_pkg::ACT_READ
                                                  : tnst_pkg::ACT_OFFER;
      r.owner      = ($urandom_range(0, 9) < 8) ? owner_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : $urandom();
      r.item       = item_t'($urandom_range(0, 65535));
      r.privileged = ($urandom_range(0, 9) == 0);
      r.qualifies  = ($urandom_range(0, 9) != 0);
      r.rank       = rank_t'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.score = $urandom_range(0, 15);
      else if (pick < 70) r.score = $urandom();
      else if (pick < 85) r.score = 32'hFFFF_FFFF - $urandom_range(0, 3);
      else                r.score = '0;
      send_request(r);
    end
    req_if.valid <= 1'b0;

    while (board.owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d offers taken, %0d offers dropped,",
             board.offers_taken, board.offers_dropped);
    $display("%0d reads in range and %0d past the count; %0d entries held at the end",
             board.reads_hit, board.reads_miss, board.fill);
    if (board.mismatches == 0 && board.owed_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* top_n_score_table_core.f */
+incdir+sv
sv/tnst_pkg.sv
sv/tnst_in_if.sv
sv/tnst_out_if.sv
sv/tnst_ram.sv
sv/top_n_score_table_core.sv
tb/top_n_score_table_core_tb.sv
